// ===== src/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants for the checkpointed trace table.
// ----------------------------------------------------------------------------
package ctt_pkg;

	localparam int Capacity  = 64;
	localparam int KeyBits   = 32;
	localparam int ValueBits = 32;
	localparam int IdxBits   = $clog2(Capacity);
	localparam int CntBits   = $clog2(Capacity + 1);

	typedef enum logic [2:0] {
		KIND_START  = 3'd0,
		KIND_VISIT  = 3'd1,
		KIND_END    = 3'd2,
		KIND_REVERT = 3'd3,
		KIND_LOOKUP = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_TRACE = 2'd1,
		ST_NO_ENTRY = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Flag bit positions.
	localparam int FSave = 0;
	localparam int FWas  = 1;
	localparam int FAct  = 2;
	localparam int FRor  = 3;
	localparam int FCrev = 4;

	typedef logic [ValueBits:0] value_t;

	typedef struct packed {
		logic [KeyBits-1:0] key;
		value_t             now;
		value_t             alt;
		logic [4:0]         flags;
	} entry_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic                save_mode;
		logic [KeyBits-1:0]  key;
		logic [31:0]         item_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic        active;
		logic [31:0] cur_value;
		logic        cur_forget;
		logic [7:0]  active_count;
	} out_word_t;

endpackage

// ===== src/ctt_if.sv =====
// ----------------------------------------------------------------------------
// ctt_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface ctt_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/ctt_ram.sv =====
// ----------------------------------------------------------------------------
// ctt_ram
// Simple dual-port synchronous entry memory with a registered read port.
// ----------------------------------------------------------------------------
module ctt_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ctt_pkg::IdxBits-1:0] waddr,
	input  ctt_pkg::entry_t             wdata,
	input  logic [ctt_pkg::IdxBits-1:0] raddr,
	output ctt_pkg::entry_t             rdata
);
	ctt_pkg::entry_t mem [ctt_pkg::Capacity];

	// One write port and one registered read port; a read of the address
	// being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/checkpointed_trace_table.sv =====
// ----------------------------------------------------------------------------
// checkpointed_trace_table
// Keyed table with a one-level checkpoint, swept entry by entry.
// ----------------------------------------------------------------------------
// Usage: words enter on in_ch (kind, save_mode, key, item_value) and each
// gives exactly one result word on out_ch. Entries live in one synchronous
// memory with a read port and a write port; valid bits sit in flip-flops.
// Every item except an unknown kind walks the memory one address per cycle,
// reading an entry and writing the changed entry back when its data returns.
// The result is loaded into the output register from S_FIN once the walk is
// done, and the next word is accepted in S_IDLE after that; unknown kinds
// skip the walk and go straight to S_FIN.
// Visits and lookups do the key search on this walk.
// Items are processed one at a time. The result sits in an output register;
// while the receiver stalls the next word is still accepted and processed,
// and its result waits until the register is freed.
// Reset clears the valid bits and control state; memory contents are left
// undefined and are never read for an invalid entry. No clearing pass is
// needed.
// ----------------------------------------------------------------------------
module checkpointed_trace_table (
	input  logic clk,
	input  logic arst_n,
	ctt_if.sink   in_ch,
	ctt_if.source out_ch
);
	localparam int N = ctt_pkg::Capacity;
	localparam int W = ctt_pkg::IdxBits;
	localparam int C = ctt_pkg::CntBits;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t             state_q;
	ctt_pkg::in_word_t  req_q;
	logic [N-1:0]       valid_q;
	logic               trace_rev_q, pend_q;
	logic [7:0]         vcount_q;
	logic [C-1:0]       addr_q;    // address issued for read
	logic               rd_s1;     // read data valid for entry idx_s1
	logic [W-1:0]       idx_s1;
	logic               hit_q, free_q, err_q;
	logic [W-1:0]       hit_idx_q, free_idx_q;
	ctt_pkg::entry_t    hit_ent_q;
	ctt_pkg::out_word_t res_q;
	logic               res_v_q;

	logic               walk_we, fin_we, fin_fire, ram_we, ent_valid, key_kind;
	logic [W-1:0]       ram_waddr;
	ctt_pkg::entry_t    e, walk_w, vis_e, ram_wdata;
	ctt_pkg::value_t    new_val;
	logic [7:0]         vcount_inc;
	ctt_pkg::out_word_t res_next;

	assign new_val = {1'b0, req_q.item_value[ctt_pkg::ValueBits-1:0]};

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = res_v_q;
	assign out_ch.data  = res_q;
	assign ent_valid    = valid_q[idx_s1];
	assign key_kind     = (req_q.kind == ctt_pkg::KIND_VISIT)
		|| (req_q.kind == ctt_pkg::KIND_LOOKUP);
	assign fin_fire     = (state_q == S_FIN) && (!res_v_q || out_ch.ready);
	assign fin_we       = fin_fire && (req_q.kind == ctt_pkg::KIND_VISIT) && (hit_q || free_q);
	assign vcount_inc   = (vcount_q != 8'hFF) ? vcount_q + 8'd1 : vcount_q;

	ctt_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q[W-1:0]),
		.rdata (e)
	);

	// Entry modification for start, end and revert walks.
	always_comb begin
		walk_we = 1'b0;
		walk_w  = e;
		if (state_q == S_WALK && rd_s1 && ent_valid) begin
			unique case (req_q.kind)
				ctt_pkg::KIND_START: begin
					walk_we = 1'b1;
					if (pend_q) walk_w.flags[ctt_pkg::FSave] = e.flags[ctt_pkg::FAct];
					walk_w.flags[ctt_pkg::FWas] = e.flags[ctt_pkg::FAct];
					walk_w.flags[ctt_pkg::FAct] = 1'b0;
				end
				ctt_pkg::KIND_END: begin
					walk_we = !pend_q && e.flags[ctt_pkg::FWas] && !e.flags[ctt_pkg::FAct]
						&& e.flags[ctt_pkg::FSave];
					walk_w.flags[ctt_pkg::FRor] = 1'b1;
				end
				ctt_pkg::KIND_REVERT: begin
					walk_we = trace_rev_q && e.flags[ctt_pkg::FSave];
					if ((e.flags[ctt_pkg::FAct] || e.flags[ctt_pkg::FRor])
						&& e.flags[ctt_pkg::FCrev]) begin
						walk_w.now = e.alt;
						walk_w.alt = e.now;
					end
					walk_w.flags[ctt_pkg::FAct]  = 1'b1;
					walk_w.flags[ctt_pkg::FSave] = 1'b0;
					walk_w.flags[ctt_pkg::FRor]  = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// The visit write uses the entry captured when the key search hit, or a fresh entry for the key when it missed.
	always_comb begin
		vis_e = hit_ent_q;
		if (hit_q) begin
			if (hit_ent_q.flags[ctt_pkg::FWas]) begin
				if (pend_q) begin
					vis_e.alt = hit_ent_q.now;
					vis_e.flags[ctt_pkg::FCrev] = 1'b1;
				end
				vis_e.now = new_val;
			end else begin
				vis_e.now = new_val | (ctt_pkg::value_t'(1) << ctt_pkg::ValueBits);
			end
			vis_e.flags[ctt_pkg::FAct] = 1'b1;
		end else begin
			vis_e.key   = req_q.key;
			vis_e.now   = new_val;
			vis_e.alt   = '0;
			vis_e.flags = 5'(1 << ctt_pkg::FAct);
		end
	end

	// Write port shared between the walk and the final visit write.
	assign ram_we    = walk_we || fin_we;
	assign ram_waddr = fin_we ? (hit_q ? hit_idx_q : free_idx_q) : idx_s1;
	assign ram_wdata = fin_we ? vis_e : walk_w;

	// Result word of the item in hand.
	always_comb begin
		res_next = '0;
		res_next.active_count = vcount_q;
		unique case (req_q.kind)
			ctt_pkg::KIND_VISIT: begin
				if (!hit_q && !free_q) res_next.status = ctt_pkg::ST_FULL;
				res_next.active_count = vcount_inc;
			end
			ctt_pkg::KIND_REVERT: begin
				if (!trace_rev_q) res_next.status = ctt_pkg::ST_NO_TRACE;
				else if (err_q) res_next.status = ctt_pkg::ST_NO_ENTRY;
			end
			ctt_pkg::KIND_LOOKUP: begin
				if (hit_q) begin
					res_next.found      = 1'b1;
					res_next.active     = hit_ent_q.flags[ctt_pkg::FAct];
					res_next.cur_value  = hit_ent_q.now[ctt_pkg::ValueBits-1:0];
					res_next.cur_forget = hit_ent_q.now[ctt_pkg::ValueBits];
				end
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			valid_q <= '0;
			trace_rev_q <= 1'b0;
			pend_q <= 1'b0;
			vcount_q <= '0;
			addr_q <= '0;
			rd_s1 <= 1'b0;
			idx_s1 <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			err_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			hit_ent_q <= '0;
			res_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= fin_fire || (res_v_q && !out_ch.ready);
			if (fin_fire) res_q <= res_next;
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					req_q <= in_ch.data;
					addr_q <= '0;
					rd_s1 <= 1'b0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
					err_q <= 1'b0;
					if (in_ch.data.kind == ctt_pkg::KIND_START) begin
						pend_q <= in_ch.data.save_mode;
						vcount_q <= '0;
					end else if (in_ch.data.kind == ctt_pkg::KIND_REVERT && trace_rev_q) begin
						vcount_q <= '0;
					end
					state_q <= (in_ch.data.kind > ctt_pkg::KIND_LOOKUP) ? S_FIN : S_WALK;
				end
				S_WALK: begin
					rd_s1  <= (addr_q < C'(N));
					idx_s1 <= addr_q[W-1:0];
					if (addr_q < C'(N)) addr_q <= addr_q + C'(1);
					if (rd_s1) begin
						if (ent_valid && key_kind && e.key == req_q.key && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= idx_s1;
							hit_ent_q <= e;
						end
						if (!ent_valid && !free_q) begin
							free_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (ent_valid) begin
							if (req_q.kind == ctt_pkg::KIND_END && !e.flags[ctt_pkg::FAct]
								&& !e.flags[ctt_pkg::FSave]) valid_q[idx_s1] <= 1'b0;
							if (req_q.kind == ctt_pkg::KIND_REVERT && trace_rev_q) begin
								if (!e.flags[ctt_pkg::FSave]) valid_q[idx_s1] <= 1'b0;
								else begin
									vcount_q <= vcount_inc;
									if ((e.flags[ctt_pkg::FAct] || e.flags[ctt_pkg::FRor])
										&& !e.flags[ctt_pkg::FCrev]) err_q <= 1'b1;
								end
							end
						end
						// The last entry has come back: finish the item.
						if (idx_s1 == W'(N - 1)) state_q <= S_FIN;
					end
				end
				S_FIN: if (fin_fire) begin
					unique case (req_q.kind)
						ctt_pkg::KIND_VISIT: begin
							vcount_q <= vcount_inc;
							if (!hit_q && free_q) valid_q[free_idx_q] <= 1'b1;
						end
						ctt_pkg::KIND_END: begin
							if (pend_q) trace_rev_q <= 1'b1;
						end
						ctt_pkg::KIND_REVERT: begin
							trace_rev_q <= 1'b0;
						end
						default: ;
					endcase
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Assertions.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> state_q != S_IDLE)
		else $error("accepted word did not start processing");
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_WALK || state_q == S_FIN)
		else $error("memory written outside a walk");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> $past(state_q) == S_FIN)
		else $error("result without a finished item");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result word changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");
endmodule

// ===== bench/checkpointed_trace_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checkpointed_trace_table_test
// Self-checking bench for the checkpointed trace table. Words are sent
// through the input channel with random gaps. A predictor in this bench works
// out each result, and every result taken from the output channel, under
// random stalls, is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module checkpointed_trace_table_test;

	localparam logic [2:0] KindSpareLo  = 3'd5;
	localparam logic [2:0] KindSpareMid = 3'd6;
	localparam logic [2:0] KindSpareHi  = 3'd7;
	localparam int PoolSize = 20;

	logic clk;
	logic arst_n;

	ctt_if #(.word_t(ctt_pkg::in_word_t))  in_ch ();
	ctt_if #(.word_t(ctt_pkg::out_word_t)) out_ch ();

	checkpointed_trace_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Predicted table contents.
	logic                        tbl_valid [ctt_pkg::Capacity];
	logic [ctt_pkg::KeyBits-1:0] tbl_key   [ctt_pkg::Capacity];
	ctt_pkg::value_t             tbl_now   [ctt_pkg::Capacity];
	ctt_pkg::value_t             tbl_alt   [ctt_pkg::Capacity];
	logic [4:0]                  tbl_flags [ctt_pkg::Capacity];
	logic                        trace_saved;
	logic [7:0]                  visits_seen;
	logic                        save_armed;

	ctt_pkg::out_word_t          expected_words [$];
	logic [ctt_pkg::KeyBits-1:0] key_pool [PoolSize];
	int                          errors;
	int                          words_sent;
	int                          words_checked;
	int                          full_hits;
	int                          unrevertible_hits;
	bit                          no_idle;

	// Clock.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int table_find(logic [ctt_pkg::KeyBits-1:0] k);
		for (int i = 0; i < ctt_pkg::Capacity; i++)
			if (tbl_valid[i] && tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic int table_free();
		for (int i = 0; i < ctt_pkg::Capacity; i++)
			if (!tbl_valid[i])
				return i;
		return -1;
	endfunction

	// Works out the result of one word and updates the predicted table.
	function automatic ctt_pkg::out_word_t table_apply(ctt_pkg::in_word_t w);
		ctt_pkg::out_word_t r;
		int                 s;
		logic [4:0]         f;
		ctt_pkg::value_t    t;
		r = '0;
		case (w.kind)
			ctt_pkg::KIND_START: begin
				save_armed = w.save_mode;
				for (int i = 0; i < ctt_pkg::Capacity; i++) begin
					if (!tbl_valid[i])
						continue;
					f = tbl_flags[i];
					if (save_armed)
						f[ctt_pkg::FSave] = f[ctt_pkg::FAct];
					f[ctt_pkg::FWas] = f[ctt_pkg::FAct];
					f[ctt_pkg::FAct] = 1'b0;
					tbl_flags[i] = f;
				end
				visits_seen = '0;
			end
			ctt_pkg::KIND_VISIT: begin
				if (visits_seen != 8'd255)
					visits_seen++;
				s = table_find(w.key);
				if (s >= 0) begin
					if (tbl_flags[s][ctt_pkg::FWas]) begin
						if (save_armed) begin
							tbl_alt[s] = tbl_now[s];
							tbl_flags[s][ctt_pkg::FCrev] = 1'b1;
						end
						tbl_now[s] = {1'b0, w.item_value};
					end else begin
						tbl_now[s] = {1'b1, w.item_value};
					end
					tbl_flags[s][ctt_pkg::FAct] = 1'b1;
				end else begin
					s = table_free();
					if (s < 0) begin
						r.status = ctt_pkg::ST_FULL;
					end else begin
						tbl_valid[s] = 1'b1;
						tbl_key[s]   = w.key;
						tbl_now[s]   = {1'b0, w.item_value};
						tbl_alt[s]   = '0;
						tbl_flags[s] = '0;
						tbl_flags[s][ctt_pkg::FAct] = 1'b1;
					end
				end
			end
			ctt_pkg::KIND_END: begin
				for (int i = 0; i < ctt_pkg::Capacity; i++) begin
					if (!tbl_valid[i])
						continue;
					f = tbl_flags[i];
					if (!f[ctt_pkg::FAct] && !f[ctt_pkg::FSave])
						tbl_valid[i] = 1'b0;
					else if (!save_armed && f[ctt_pkg::FWas] && !f[ctt_pkg::FAct])
						tbl_flags[i][ctt_pkg::FRor] = 1'b1;
				end
				if (save_armed)
					trace_saved = 1'b1;
			end
			ctt_pkg::KIND_REVERT: begin
				if (!trace_saved) begin
					r.status = ctt_pkg::ST_NO_TRACE;
				end else begin
					trace_saved = 1'b0;
					visits_seen = '0;
					for (int i = 0; i < ctt_pkg::Capacity; i++) begin
						if (!tbl_valid[i])
							continue;
						f = tbl_flags[i];
						if (!f[ctt_pkg::FSave]) begin
							tbl_valid[i] = 1'b0;
							continue;
						end
						if (f[ctt_pkg::FAct] || f[ctt_pkg::FRor]) begin
							if (f[ctt_pkg::FCrev]) begin
								t = tbl_now[i];
								tbl_now[i] = tbl_alt[i];
								tbl_alt[i] = t;
							end else begin
								r.status = ctt_pkg::ST_NO_ENTRY;
							end
						end
						if (visits_seen != 8'd255)
							visits_seen++;
						f[ctt_pkg::FAct]  = 1'b1;
						f[ctt_pkg::FSave] = 1'b0;
						f[ctt_pkg::FRor]  = 1'b0;
						tbl_flags[i] = f;
					end
				end
			end
			ctt_pkg::KIND_LOOKUP: begin
				s = table_find(w.key);
				if (s >= 0) begin
					r.found      = 1'b1;
					r.active     = tbl_flags[s][ctt_pkg::FAct];
					r.cur_value  = tbl_now[s][ctt_pkg::ValueBits-1:0];
					r.cur_forget = tbl_now[s][ctt_pkg::ValueBits];
				end
			end
			default: begin
			end
		endcase
		r.active_count = visits_seen;
		if (r.status == ctt_pkg::ST_FULL)
			full_hits++;
		if (r.status == ctt_pkg::ST_NO_ENTRY)
			unrevertible_hits++;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one word and records its predicted result once accepted.
	task automatic send_word(logic [2:0] kind, logic save, logic [ctt_pkg::KeyBits-1:0] key,
			logic [31:0] val);
		ctt_pkg::in_word_t w;
		int                gap;
		logic              rdy;
		w.kind       = kind;
		w.save_mode  = save;
		w.key        = key;
		w.item_value = val;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= w;
		do begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end while (!rdy);
		expected_words.push_back(table_apply(w));
		words_sent++;
	endtask

	// Withdraws the input and waits until every expected result has come.
	task automatic drain();
		in_ch.valid <= 1'b0;
		wait (expected_words.size() == 0);
		@(posedge clk);
	endtask

	// Receiver: random stalls, result checked against the oldest prediction.
	initial begin
		int                 stall;
		logic               v;
		logic               r;
		ctt_pkg::out_word_t got;
		ctt_pkg::out_word_t exp_w;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			v   = out_ch.valid;
			r   = out_ch.ready;
			got = out_ch.data;
			@(posedge clk);
			if (arst_n && v && r) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $time, got);
					errors++;
				end else begin
					exp_w = expected_words.pop_front();
					words_checked++;
					if (got.status !== exp_w.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_w.status, got.status);
						errors++;
					end
					if (got.found !== exp_w.found) begin
						$display("%0t: found expected %0d actual %0d", $time,
							exp_w.found, got.found);
						errors++;
					end
					if (got.active !== exp_w.active) begin
						$display("%0t: active expected %0d actual %0d", $time,
							exp_w.active, got.active);
						errors++;
					end
					if (got.cur_value !== exp_w.cur_value) begin
						$display("%0t: cur_value expected %h actual %h", $time,
							exp_w.cur_value, got.cur_value);
						errors++;
					end
					if (got.cur_forget !== exp_w.cur_forget) begin
						$display("%0t: cur_forget expected %0d actual %0d", $time,
							exp_w.cur_forget, got.cur_forget);
						errors++;
					end
					if (got.active_count !== exp_w.active_count) begin
						$display("%0t: active_count expected %0d actual %0d", $time,
							exp_w.active_count, got.active_count);
						errors++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				stall = pick_gap();
				out_ch.ready <= (stall == 0);
			end
		end
	end

	// Directed: empty table, revert with no checkpoint, unknown kinds, extremes.
	task automatic test_basics();
		send_word(ctt_pkg::KIND_REVERT, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_LOOKUP, 1'b0, '0, '0);
		send_word(KindSpareLo, 1'b1, '1, '1);
		send_word(KindSpareMid, 1'b0, '0, '0);
		send_word(KindSpareHi, 1'b1, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
		send_word(ctt_pkg::KIND_START, 1'b1, '0, '0);
		send_word(ctt_pkg::KIND_VISIT, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_VISIT, 1'b0, '1, '1);
		send_word(ctt_pkg::KIND_VISIT, 1'b0, '1, 32'h1234_5678);
		send_word(ctt_pkg::KIND_END, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_LOOKUP, 1'b0, '1, '0);
		send_word(ctt_pkg::KIND_START, 1'b1, '0, '0);
		send_word(ctt_pkg::KIND_VISIT, 1'b0, '1, 32'h8000_0001);
		send_word(ctt_pkg::KIND_END, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_LOOKUP, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_LOOKUP, 1'b0, '1, '0);
		send_word(ctt_pkg::KIND_REVERT, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_LOOKUP, 1'b0, '1, '0);
		send_word(ctt_pkg::KIND_LOOKUP, 1'b0, '0, '0);
	endtask

	// A saved entry that is revisited after an unsaved start gets no alternate,
	// so the revert cannot swap it back.
	task automatic test_unrevertible();
		send_word(ctt_pkg::KIND_START, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_VISIT, 1'b0, 32'h0000_0077, 32'hCAFE_0001);
		send_word(ctt_pkg::KIND_END, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_START, 1'b1, '0, '0);
		send_word(ctt_pkg::KIND_END, 1'b1, '0, '0);
		send_word(ctt_pkg::KIND_START, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_VISIT, 1'b0, 32'h0000_0077, 32'hCAFE_0002);
		send_word(ctt_pkg::KIND_LOOKUP, 1'b0, 32'h0000_0077, '0);
		send_word(ctt_pkg::KIND_REVERT, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_LOOKUP, 1'b0, 32'h0000_0077, '0);
	endtask

	// Overfill the table, then saturate the visit count, then clear it out.
	task automatic test_full_and_saturation();
		send_word(ctt_pkg::KIND_START, 1'b0, '0, '0);
		for (int i = 0; i < ctt_pkg::Capacity + 4; i++)
			send_word(ctt_pkg::KIND_VISIT, 1'b0, 32'h0100_0000 + i, $urandom);
		for (int i = 0; i < 200; i++)
			send_word(ctt_pkg::KIND_VISIT, 1'b0, 32'h0100_0000 + (i % 8), $urandom);
		send_word(ctt_pkg::KIND_END, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_START, 1'b0, '0, '0);
		send_word(ctt_pkg::KIND_END, 1'b0, '0, '0);
	endtask

	function automatic logic [ctt_pkg::KeyBits-1:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, PoolSize - 1)];
	endfunction

	// Random updates with random content, plus lookups, reverts and noise.
	task automatic test_random(int n_words);
		int base;
		int n;
		base = words_sent;
		while (words_sent - base < n_words) begin
			no_idle = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) < 8) begin
				send_word(ctt_pkg::KIND_START, 1'($urandom_range(0, 1)), $urandom, $urandom);
				n = $urandom_range(0, 12);
				for (int i = 0; i < n; i++)
					send_word(ctt_pkg::KIND_VISIT, 1'($urandom_range(0, 1)), pick_key(),
						$urandom);
				send_word(ctt_pkg::KIND_END, 1'($urandom_range(0, 1)), $urandom, $urandom);
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					send_word(ctt_pkg::KIND_LOOKUP, 1'($urandom_range(0, 1)), pick_key(),
						$urandom);
				if ($urandom_range(0, 5) == 0)
					send_word(ctt_pkg::KIND_REVERT, 1'($urandom_range(0, 1)), $urandom,
						$urandom);
			end else begin
				send_word(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), pick_key(),
					$urandom);
			end
			if ($urandom_range(0, 40) == 0)
				drain();
		end
		no_idle = 1'b0;
	endtask

	// Run-time limit.
	initial begin
		#12ms;
		$display("checkpointed_trace_table: mismatch");
		$finish;
	end

	// Main sequence.
	initial begin
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		full_hits = 0;
		unrevertible_hits = 0;
		no_idle = 1'b0;
		for (int i = 0; i < ctt_pkg::Capacity; i++)
			tbl_valid[i] = 1'b0;
		trace_saved = 1'b0;
		visits_seen = '0;
		save_armed = 1'b0;
		for (int i = 0; i < PoolSize; i++)
			key_pool[i] = $urandom;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basics();
		test_unrevertible();
		drain();
		test_full_and_saturation();
		test_random(1600);

		drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d words and checked %0d results.", words_sent, words_checked);
		$display("Table-full answers: %0d, unrevertible entries: %0d.", full_hits,
			unrevertible_hits);
		if (errors == 0 && expected_words.size() == 0)
			$display("checkpointed_trace_table: match");
		else
			$display("checkpointed_trace_table: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ctt_pkg.sv
src/ctt_if.sv
src/ctt_ram.sv
src/checkpointed_trace_table.sv
bench/checkpointed_trace_table_test.sv
